[hw/rtl/csfp_pkg.sv]
// Shared constants, codes and controller/datapath interface types of the frame parser.
`default_nettype none

package csfp_pkg;

   // Payload store geometry
   localparam int BUF_DEPTH = 64;
   localparam int ADDR_W    = $clog2(BUF_DEPTH);
   // Position width: holds any payload position and BUF_DEPTH itself
   localparam int POS_W     = ((ADDR_W > 6) ? ADDR_W : 6) + 1;

   localparam logic [7:0] HDR1            = 8'hAA;
   localparam logic [7:0] SECOND_HDR_RST  = 8'hAF;
   localparam logic [7:0] FUNC_LIMIT_RST  = 8'hF0;
   localparam logic [5:0] LEN_LIMIT_RST   = 6'd49;

   localparam logic [7:0] FUNC_CAL        = 8'h01;
   localparam logic [7:0] FUNC_PID_REQ    = 8'h02;
   localparam logic [7:0] FUNC_PID_FIRST  = 8'h10;
   localparam logic [7:0] FUNC_PID_LAST   = 8'h15;
   localparam logic [7:0] PID_GROUP_BASE  = 8'h0F;

   localparam logic [7:0] SUB_ACC_CAL     = 8'h01;
   localparam logic [7:0] SUB_GYRO_CAL    = 8'h02;
   localparam logic [7:0] SUB_MAG_CAL     = 8'h04;
   localparam logic [7:0] SUB_PID_REQ     = 8'h01;
   localparam logic [7:0] SUB_RESET_PARAM = 8'hA1;

   typedef enum logic [1:0] {
      CSR_SECOND_HEADER = 2'd0,
      CSR_FUNC_LIMIT    = 2'd1,
      CSR_LEN_LIMIT     = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      CMD_NONE         = 3'd0,
      CMD_ACC_CAL      = 3'd1,
      CMD_GYRO_CAL     = 3'd2,
      CMD_MAG_CAL      = 3'd3,
      CMD_PID_REQ      = 3'd4,
      CMD_RESET_PARAMS = 3'd5,
      CMD_ALL_PID      = 3'd6
   } command_type;

   // Controller -> datapath
   typedef struct packed {
      logic ld_hdr2;
      logic ld_func;
      logic ld_len;
      logic ld_data;
      logic ld_check;
      logic rd_hi;
      logic rd_lo;
      logic ld_word;
      logic next_word;
      logic ld_status;
   } ctrl_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic hdr1_hit;
      logic hdr2_hit;
      logic func_ok;
      logic len_ok;
      logic len_zero;
      logic data_done;
      logic sum_ok;
      logic frame_empty;
      logic more_words;
   } dp_status_type;

endpackage

`default_nettype wire

[hw/rtl/csfp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module csfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[hw/rtl/csfp_ctrl.sv]
// Frame parser controller: parse phases and frame-end readout sequencing.
`default_nettype none

module csfp_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire csfp_pkg::dp_status_type status,
   output csfp_pkg::ctrl_cmd_type       cmd
);
   import csfp_pkg::*;

   typedef enum logic [11:0] {
      S_HUNT1      = 12'b0000_0000_0001,
      S_HUNT2      = 12'b0000_0000_0010,
      S_FUNC       = 12'b0000_0000_0100,
      S_LEN        = 12'b0000_0000_1000,
      S_DATA       = 12'b0000_0001_0000,
      S_SUM        = 12'b0000_0010_0000,
      S_RD_HI      = 12'b0000_0100_0000,
      S_RD_LO      = 12'b0000_1000_0000,
      S_RD_GET     = 12'b0001_0000_0000,
      S_WORD_OUT   = 12'b0010_0000_0000,
      S_STATUS_LD  = 12'b0100_0000_0000,
      S_STATUS_OUT = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      req_fire;

   assign req_ready = state_ff inside {S_HUNT1, S_HUNT2, S_FUNC, S_LEN, S_DATA, S_SUM};
   assign rsp_valid = state_ff inside {S_WORD_OUT, S_STATUS_OUT};
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_HUNT1: begin
            if (req_fire) begin
               state_in = status.hdr1_hit ? S_HUNT2 : S_HUNT1;
            end
         end
         S_HUNT2: begin
            if (req_fire) begin
               if (status.hdr2_hit) begin
                  cmd.ld_hdr2 = 1'b1;
                  state_in    = S_FUNC;
               end else begin
                  state_in = S_HUNT1;
               end
            end
         end
         S_FUNC: begin
            if (req_fire) begin
               if (status.func_ok) begin
                  cmd.ld_func = 1'b1;
                  state_in    = S_LEN;
               end else begin
                  state_in = S_HUNT1;
               end
            end
         end
         S_LEN: begin
            if (req_fire) begin
               if (status.len_ok) begin
                  cmd.ld_len = 1'b1;
                  // empty frame: checksum byte comes next
                  state_in   = status.len_zero ? S_SUM : S_DATA;
               end else begin
                  state_in = S_HUNT1;
               end
            end
         end
         S_DATA: begin
            if (req_fire) begin
               cmd.ld_data = 1'b1;
               if (status.data_done) begin
                  state_in = S_SUM;
               end
            end
         end
         S_SUM: begin
            if (req_fire) begin
               cmd.ld_check = 1'b1;
               state_in     = (status.sum_ok && !status.frame_empty) ? S_RD_HI : S_STATUS_LD;
            end
         end
         S_RD_HI: begin
            cmd.rd_hi = 1'b1;
            state_in  = S_RD_LO;
         end
         S_RD_LO: begin
            cmd.rd_lo = 1'b1;
            state_in  = S_RD_GET;
         end
         S_RD_GET: begin
            cmd.ld_word = 1'b1;
            state_in    = S_WORD_OUT;
         end
         S_WORD_OUT: begin
            if (rsp_ready) begin
               if (status.more_words) begin
                  cmd.next_word = 1'b1;
                  state_in      = S_RD_HI;
               end else begin
                  state_in = S_STATUS_LD;
               end
            end
         end
         S_STATUS_LD: begin
            cmd.ld_status = 1'b1;
            state_in      = S_STATUS_OUT;
         end
         S_STATUS_OUT: begin
            if (rsp_ready) begin
               state_in = S_HUNT1;
            end
         end
         default: begin
            state_in = S_HUNT1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_HUNT1;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/csfp_datapath.sv]
// Frame parser datapath: settings, frame fields, checksum, payload store and result register.
`default_nettype none

module csfp_datapath (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_wr_en,
   input  wire logic [1:0]              csr_index,
   input  wire logic [7:0]              csr_wdata,
   input  wire logic [7:0]              req_rx_byte,
   input  wire csfp_pkg::ctrl_cmd_type  cmd,
   output csfp_pkg::dp_status_type      status,
   output logic                         rsp_is_status,
   output logic [4:0]                   rsp_word_index,
   output logic [15:0]                  rsp_word_value,
   output logic                         rsp_frame_ok,
   output logic [7:0]                   rsp_func_code,
   output logic [5:0]                   rsp_payload_len,
   output logic [2:0]                   rsp_command,
   output logic [2:0]                   rsp_pid_group,
   output logic                         rsp_ack_needed,
   output logic [7:0]                   rsp_ack_checksum,
   output logic                         rsp_last
);
   import csfp_pkg::*;

   logic [7:0]       second_header_ff, func_limit_ff;
   logic [5:0]       len_limit_ff;
   logic [5:0]       expected_len_ff, byte_count_ff;
   logic [7:0]       running_sum_ff, frame_func_ff, first_byte_ff;
   logic             sum_ok_ff;
   logic [4:0]       word_ff;
   logic [7:0]       hi_ff;
   logic             keep_ff;

   logic [POS_W-1:0] byte_pos, pos_hi, pos_lo, rd_pos;
   logic             wr_en, rd_en;
   logic [7:0]       rd_data, rd_byte;
   logic [5:0]       word_total;
   logic [2:0]       pid_grp;
   command_type      cmd_code;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         second_header_ff <= SECOND_HDR_RST;
         func_limit_ff    <= FUNC_LIMIT_RST;
         len_limit_ff     <= LEN_LIMIT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SECOND_HEADER: second_header_ff <= csr_wdata;
            CSR_FUNC_LIMIT:    func_limit_ff    <= csr_wdata;
            CSR_LEN_LIMIT:     len_limit_ff     <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   assign byte_pos   = POS_W'(byte_count_ff);
   assign pos_hi     = POS_W'({word_ff, 1'b0});
   assign pos_lo     = POS_W'({word_ff, 1'b1});
   assign rd_pos     = cmd.rd_lo ? pos_lo : pos_hi;
   assign wr_en      = cmd.ld_data && (byte_pos < POS_W'(BUF_DEPTH));
   assign rd_en      = cmd.rd_hi || cmd.rd_lo;
   assign rd_byte    = keep_ff ? rd_data : 8'h00;
   assign word_total = 6'((7'(expected_len_ff) + 7'd1) >> 1);

   always_comb begin
      status.hdr1_hit    = req_rx_byte == HDR1;
      status.hdr2_hit    = req_rx_byte == second_header_ff;
      status.func_ok     = req_rx_byte <= func_limit_ff;
      status.len_ok      = req_rx_byte <= {2'b00, len_limit_ff};
      status.len_zero    = req_rx_byte[5:0] == 6'd0;
      status.data_done   = (7'(byte_count_ff) + 7'd1) >= 7'(expected_len_ff);
      status.sum_ok      = req_rx_byte == running_sum_ff;
      status.frame_empty = expected_len_ff == 6'd0;
      status.more_words  = (6'(word_ff) + 6'd1) < word_total;
   end

   // Frame fields and running checksum
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_len_ff <= '0;
         byte_count_ff   <= '0;
         running_sum_ff  <= '0;
         frame_func_ff   <= '0;
         sum_ok_ff       <= 1'b0;
         word_ff         <= '0;
         keep_ff         <= 1'b0;
      end else begin
         if (cmd.ld_hdr2) begin
            running_sum_ff <= HDR1 + req_rx_byte;
         end
         if (cmd.ld_func) begin
            frame_func_ff  <= req_rx_byte;
            running_sum_ff <= running_sum_ff + req_rx_byte;
         end
         if (cmd.ld_len) begin
            expected_len_ff <= req_rx_byte[5:0];
            byte_count_ff   <= '0;
            running_sum_ff  <= running_sum_ff + req_rx_byte;
         end
         if (cmd.ld_data) begin
            running_sum_ff <= running_sum_ff + req_rx_byte;
            byte_count_ff  <= byte_count_ff + 6'd1;
         end
         if (cmd.ld_check) begin
            sum_ok_ff <= status.sum_ok;
            word_ff   <= '0;
         end
         if (cmd.next_word) begin
            word_ff <= word_ff + 5'd1;
         end
         // Mark whether the byte being read is real payload or reads as zero
         if (cmd.rd_hi) begin
            keep_ff <= pos_hi < POS_W'(BUF_DEPTH);
         end else if (cmd.rd_lo) begin
            keep_ff <= (pos_lo < POS_W'(BUF_DEPTH)) && (pos_lo < POS_W'(expected_len_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_data && (byte_count_ff == 6'd0)) begin
         first_byte_ff <= req_rx_byte;
      end
      if (cmd.rd_lo) begin
         hi_ff <= rd_byte;
      end
   end

   csfp_ram #(
      .WIDTH (8),
      .DEPTH (BUF_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (byte_pos[ADDR_W-1:0]),
      .wr_data (req_rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_pos[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // Command decode for the status transaction of a good frame
   always_comb begin
      cmd_code = CMD_NONE;
      if (frame_func_ff == FUNC_CAL && expected_len_ff != 6'd0) begin
         case (first_byte_ff)
            SUB_ACC_CAL:  cmd_code = CMD_ACC_CAL;
            SUB_GYRO_CAL: cmd_code = CMD_GYRO_CAL;
            SUB_MAG_CAL:  cmd_code = CMD_MAG_CAL;
            default:      cmd_code = CMD_NONE;
         endcase
      end else if (frame_func_ff == FUNC_PID_REQ && expected_len_ff != 6'd0) begin
         case (first_byte_ff)
            SUB_PID_REQ:     cmd_code = CMD_PID_REQ;
            SUB_RESET_PARAM: cmd_code = CMD_RESET_PARAMS;
            default:         cmd_code = CMD_NONE;
         endcase
      end else if (frame_func_ff == FUNC_PID_LAST) begin
         cmd_code = CMD_ALL_PID;
      end
   end

   always_comb begin
      if (frame_func_ff inside {[FUNC_PID_FIRST:FUNC_PID_LAST]}) begin
         pid_grp = 3'(frame_func_ff - PID_GROUP_BASE);
      end else begin
         pid_grp = 3'd0;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.ld_word) begin
         rsp_is_status    <= 1'b0;
         rsp_word_index   <= word_ff;
         rsp_word_value   <= {hi_ff, rd_byte};
         rsp_frame_ok     <= 1'b1;
         rsp_func_code    <= frame_func_ff;
         rsp_payload_len  <= expected_len_ff;
         rsp_command      <= CMD_NONE;
         rsp_pid_group    <= 3'd0;
         rsp_ack_needed   <= 1'b0;
         rsp_ack_checksum <= 8'h00;
         rsp_last         <= 1'b0;
      end else if (cmd.ld_status) begin
         rsp_is_status    <= 1'b1;
         rsp_word_index   <= 5'd0;
         rsp_word_value   <= 16'h0000;
         rsp_frame_ok     <= sum_ok_ff;
         rsp_func_code    <= frame_func_ff;
         rsp_payload_len  <= expected_len_ff;
         rsp_command      <= sum_ok_ff ? cmd_code : CMD_NONE;
         rsp_pid_group    <= sum_ok_ff ? pid_grp : 3'd0;
         rsp_ack_needed   <= sum_ok_ff && (pid_grp != 3'd0);
         rsp_ack_checksum <= running_sum_ff;
         rsp_last         <= 1'b1;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/checked_serial_frame_parser.sv]
// Top level of the checked serial frame parser.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_rx_byte
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_is_status .. rsp_last
//   csr     | in        | csr_wr_en            | csr_index, csr_wdata
//
// The parser accepts one byte a cycle until the checksum byte. At frame end
// the store is read through its single read port, two reads per word (high
// byte, low byte) before each word is loaded and presented, then the status
// transaction; no byte is accepted until the status transaction is taken.
// Reset is synchronous and returns the parser to the header hunt.
// A stalled rsp_ready holds the result register and the readout.
`default_nettype none

module checked_serial_frame_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_is_status,
   output logic [4:0]       rsp_word_index,
   output logic [15:0]      rsp_word_value,
   output logic             rsp_frame_ok,
   output logic [7:0]       rsp_func_code,
   output logic [5:0]       rsp_payload_len,
   output logic [2:0]       rsp_command,
   output logic [2:0]       rsp_pid_group,
   output logic             rsp_ack_needed,
   output logic [7:0]       rsp_ack_checksum,
   output logic             rsp_last,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);
   import csfp_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   csfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   csfp_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_rx_byte      (req_rx_byte),
      .cmd              (cmd),
      .status           (status),
      .rsp_is_status    (rsp_is_status),
      .rsp_word_index   (rsp_word_index),
      .rsp_word_value   (rsp_word_value),
      .rsp_frame_ok     (rsp_frame_ok),
      .rsp_func_code    (rsp_func_code),
      .rsp_payload_len  (rsp_payload_len),
      .rsp_command      (rsp_command),
      .rsp_pid_group    (rsp_pid_group),
      .rsp_ack_needed   (rsp_ack_needed),
      .rsp_ack_checksum (rsp_ack_checksum),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

[hw/rtl/csfp_checker.sv]
// Port-level checker for the frame parser, bound to the top level.
`default_nettype none

module csfp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_is_status,
   input wire logic [4:0]  rsp_word_index,
   input wire logic [15:0] rsp_word_value,
   input wire logic        rsp_frame_ok,
   input wire logic [7:0]  rsp_func_code,
   input wire logic [5:0]  rsp_payload_len,
   input wire logic [2:0]  rsp_command,
   input wire logic [2:0]  rsp_pid_group,
   input wire logic        rsp_ack_needed,
   input wire logic [7:0]  rsp_ack_checksum,
   input wire logic        rsp_last
);

   // A stalled result transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word_value)
         && $stable(rsp_word_index) && $stable(rsp_is_status)
         && $stable(rsp_func_code) && $stable(rsp_payload_len))
      else $error("result changed while stalled");

   // No byte is taken while a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input accepted during frame readout");

   // Only the status transaction closes a frame
   a_last_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last == rsp_is_status)
      else $error("last flag disagrees with status flag");

   // Word transactions carry no status content and belong to a good frame
   a_word_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_status |-> rsp_frame_ok && rsp_command == 3'd0
         && rsp_pid_group == 3'd0 && !rsp_ack_needed && rsp_ack_checksum == 8'd0)
      else $error("word transaction carries status fields");

   // A bad frame decodes nothing and asks for no acknowledge
   a_bad_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_status && !rsp_frame_ok |-> rsp_command == 3'd0
         && rsp_pid_group == 3'd0 && !rsp_ack_needed)
      else $error("bad frame decoded a command");

endmodule

bind checked_serial_frame_parser csfp_checker u_csfp_checker (.*);

`default_nettype wire
